@@ src/i2crtc_pkg.sv @@
package i2crtc_pkg;

	localparam int BUFFER_BYTES_DEF = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_WRITE = 3'd1;
	localparam logic [2:0] REQ_READ  = 3'd2;
	localparam logic [2:0] REQ_LOAD  = 3'd3;
	localparam logic [2:0] REQ_FETCH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGISTER = 2'd1;

	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd104;
	localparam logic [7:0] FIRST_REGISTER_RST = 8'd0;

	typedef struct packed {
		logic [2:0] req_type;
		logic [2:0] byte_index;
		logic [7:0] load_value;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic       ack_missing;
		logic [7:0] fetched_byte;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           value;
	} cfg_t;

	// bus side of one step, without the fetched byte
	typedef struct packed {
		logic scl;
		logic sda;
		logic en;
		logic busy;
		logic done;
		logic ack;
	} line_t;

endpackage

@@ src/i2crtc_chan_if.sv @@
interface i2crtc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/i2crtc_ram.sv @@
module i2crtc_ram #(
	parameter int W = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re_a,
	input  logic [AW-1:0] raddr_a,
	output logic [W-1:0]  rdata_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_b
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		rdata_b <= mem[raddr_b];
	end
endmodule

@@ src/i2crtc_seq.sv @@
module i2crtc_seq #(
	parameter int BUFFER_BYTES = 8,
	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1,
	localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  i2crtc_pkg::item_t  req,
	input  logic [6:0]         dev_addr,
	input  logic [7:0]         first_reg,
	input  logic [7:0]         buf_rdata,
	output logic [AW-1:0]      buf_raddr,
	output logic               buf_we,
	output logic [AW-1:0]      buf_waddr,
	output logic [7:0]         buf_wdata,
	output i2crtc_pkg::line_t  nx_line
);
	import i2crtc_pkg::*;

	localparam logic [2:0] SQ_IDLE    = 3'd0;
	localparam logic [2:0] SQ_START   = 3'd1;
	localparam logic [2:0] SQ_SEND    = 3'd2;
	localparam logic [2:0] SQ_GETACK  = 3'd3;
	localparam logic [2:0] SQ_RECV    = 3'd4;
	localparam logic [2:0] SQ_PUTACK  = 3'd5;
	localparam logic [2:0] SQ_RESTART = 3'd6;
	localparam logic [2:0] SQ_STOP    = 3'd7;

	localparam logic [1:0] STG_ADDR_W = 2'd0;
	localparam logic [1:0] STG_REG    = 2'd1;
	localparam logic [1:0] STG_DATA   = 2'd2;
	localparam logic [1:0] STG_ADDR_R = 2'd3;

	localparam logic [CW:0] BB_EXT = (CW + 1)'(BUFFER_BYTES);

	logic [2:0]    state_q, nx_state;
	logic [1:0]    stage_q, nx_stage;
	logic          rd_q, nx_rd;
	logic          half_q, nx_half;
	logic [3:0]    bit_q, nx_bit, bit_inc;
	logic [CW-1:0] byte_q, nx_byte;
	logic [CW:0]   byte_inc, nx_byte_inc;
	logic [7:0]    shift_q, nx_shift;
	logic          ack_q, nx_ack;
	logic          done_c, we_c, idle, idx_ok;
	logic [6:0]    idx_ext;

	assign idle     = (state_q == SQ_IDLE);
	assign idx_ext  = 7'(req.byte_index);
	assign idx_ok   = idx_ext < 7'(BUFFER_BYTES);
	assign bit_inc  = bit_q + 4'd1;
	assign byte_inc = {1'b0, byte_q} + 1'b1;
	assign nx_byte_inc = {1'b0, nx_byte} + 1'b1;

	// prefetch of the next byte to send; the buffer is stable during a write transfer
	assign buf_raddr = (stage_q == STG_REG) ? '0 : byte_inc[AW-1:0];

	always_comb begin
		nx_state  = state_q;
		nx_stage  = stage_q;
		nx_rd     = rd_q;
		nx_half   = half_q;
		nx_bit    = bit_q;
		nx_byte   = byte_q;
		nx_shift  = shift_q;
		nx_ack    = ack_q;
		done_c    = 1'b0;
		we_c      = 1'b0;
		buf_waddr = idx_ext[AW-1:0];
		buf_wdata = req.load_value;
		case (req.req_type)
			REQ_TICK: begin
				if (!idle) begin
					case (state_q)
						SQ_START: begin
							if (!half_q) begin
								nx_half = 1'b1;
							end else begin
								nx_state = SQ_SEND;
								nx_half  = 1'b0;
								nx_bit   = '0;
								nx_shift = {dev_addr, stage_q == STG_ADDR_R};
							end
						end
						SQ_SEND: begin
							if (!half_q) begin
								nx_half = 1'b1;
							end else begin
								nx_shift = {shift_q[6:0], 1'b0};
								nx_bit   = bit_inc;
								nx_half  = 1'b0;
								if (bit_inc >= BITS_PER_BYTE) begin
									nx_state = SQ_GETACK;
								end
							end
						end
						SQ_GETACK: begin
							if (!half_q) begin
								nx_half = 1'b1;
							end else begin
								if (req.sda_sample) begin
									nx_ack = 1'b1;
								end
								nx_half = 1'b0;
								case (stage_q)
									STG_ADDR_W: begin
										nx_stage = STG_REG;
										nx_state = SQ_SEND;
										nx_bit   = '0;
										nx_shift = first_reg;
									end
									STG_REG: begin
										nx_byte = '0;
										if (rd_q) begin
											nx_stage = STG_ADDR_R;
											nx_state = SQ_RESTART;
										end else begin
											nx_stage = STG_DATA;
											nx_state = SQ_SEND;
											nx_bit   = '0;
											nx_shift = buf_rdata;
										end
									end
									STG_ADDR_R: begin
										nx_stage = STG_DATA;
										nx_byte  = '0;
										nx_state = SQ_RECV;
										nx_bit   = '0;
										nx_shift = '0;
									end
									default: begin
										nx_byte = byte_inc[CW-1:0];
										if (byte_inc >= BB_EXT) begin
											nx_state = SQ_STOP;
										end else begin
											nx_state = SQ_SEND;
											nx_bit   = '0;
											nx_shift = buf_rdata;
										end
									end
								endcase
							end
						end
						SQ_RECV: begin
							if (!half_q) begin
								nx_half = 1'b1;
							end else begin
								nx_shift = {shift_q[6:0], req.sda_sample};
								nx_bit   = bit_inc;
								nx_half  = 1'b0;
								if (bit_inc >= BITS_PER_BYTE) begin
									if ({1'b0, byte_q} < BB_EXT) begin
										we_c      = 1'b1;
										buf_waddr = byte_q[AW-1:0];
										buf_wdata = nx_shift;
									end
									nx_state = SQ_PUTACK;
								end
							end
						end
						SQ_PUTACK: begin
							if (!half_q) begin
								nx_half = 1'b1;
							end else begin
								nx_byte = byte_inc[CW-1:0];
								nx_half = 1'b0;
								if (byte_inc >= BB_EXT) begin
									nx_state = SQ_STOP;
								end else begin
									nx_state = SQ_RECV;
									nx_bit   = '0;
									nx_shift = '0;
								end
							end
						end
						SQ_RESTART: begin
							nx_state = SQ_START;
							nx_half  = 1'b0;
						end
						SQ_STOP: begin
							if (!half_q) begin
								nx_half = 1'b1;
							end else begin
								nx_state = SQ_IDLE;
								nx_half  = 1'b0;
								done_c   = 1'b1;
							end
						end
						default: begin
							nx_state = SQ_IDLE;
							nx_half  = 1'b0;
						end
					endcase
				end
			end
			REQ_WRITE, REQ_READ: begin
				if (idle) begin
					nx_rd    = (req.req_type == REQ_READ);
					nx_stage = STG_ADDR_W;
					nx_ack   = 1'b0;
					nx_byte  = '0;
					nx_bit   = '0;
					nx_state = SQ_START;
					nx_half  = 1'b0;
				end
			end
			REQ_LOAD: begin
				we_c = idle && idx_ok;
			end
			default: begin
			end
		endcase
	end

	assign buf_we = step && we_c;

	always_comb begin
		nx_line.busy = (nx_state != SQ_IDLE);
		nx_line.done = done_c;
		nx_line.ack  = nx_ack;
		case (nx_state)
			SQ_START: begin
				nx_line.scl = 1'b1;
				nx_line.sda = !nx_half;
				nx_line.en  = 1'b1;
			end
			SQ_SEND: begin
				nx_line.scl = nx_half;
				nx_line.sda = nx_shift[7];
				nx_line.en  = 1'b1;
			end
			SQ_GETACK, SQ_RECV: begin
				nx_line.scl = nx_half;
				nx_line.sda = 1'b0;
				nx_line.en  = 1'b0;
			end
			SQ_PUTACK: begin
				nx_line.scl = nx_half;
				nx_line.sda = (nx_byte_inc >= BB_EXT);
				nx_line.en  = 1'b1;
			end
			SQ_RESTART: begin
				nx_line.scl = 1'b0;
				nx_line.sda = 1'b1;
				nx_line.en  = 1'b1;
			end
			SQ_STOP: begin
				nx_line.scl = nx_half;
				nx_line.sda = 1'b0;
				nx_line.en  = 1'b1;
			end
			default: begin
				nx_line.scl = 1'b1;
				nx_line.sda = 1'b1;
				nx_line.en  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			stage_q <= STG_ADDR_W;
			rd_q    <= 1'b0;
			half_q  <= 1'b0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			ack_q   <= 1'b0;
		end else if (step) begin
			state_q <= nx_state;
			stage_q <= nx_stage;
			rd_q    <= nx_rd;
			half_q  <= nx_half;
			bit_q   <= nx_bit;
			byte_q  <= nx_byte;
			shift_q <= nx_shift;
			ack_q   <= nx_ack;
		end
	end
endmodule

@@ src/i2c_rtc_buffer_transfer_top.sv @@
// Each accepted transaction's result is registered and shown in the next cycle.
// Throughput: one transaction per cycle unless a full, undrained result register stalls the input.
// Input is taken whenever the result register is empty or being drained.
// Reset idles the sequencer, empties the result register and returns the configuration
// registers to their defaults; buffer contents stay undefined until loaded or received.
module i2c_rtc_buffer_transfer_top #(
	parameter int BUFFER_BYTES = i2crtc_pkg::BUFFER_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	i2crtc_chan_if.sink   item,
	i2crtc_chan_if.source result,
	i2crtc_chan_if.sink   cfg
);
	import i2crtc_pkg::*;

	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

	item_t         req;
	cfg_t          cfg_w;
	logic          accept;
	logic          out_valid_q;
	line_t         line_q, nx_line;
	logic          fetch_q;
	logic [6:0]    dev_addr_q;
	logic [7:0]    first_reg_q;
	logic [6:0]    idx_ext;
	logic          fetch_c;
	logic [AW-1:0] buf_raddr, buf_waddr;
	logic          buf_we;
	logic [7:0]    buf_wdata, rdata_a, rdata_b;

	assign req        = item.data;
	assign cfg_w      = cfg.data;
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign idx_ext = 7'(req.byte_index);
	assign fetch_c = (req.req_type == REQ_FETCH) && (idx_ext < 7'(BUFFER_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= DEVICE_ADDRESS_RST;
			first_reg_q <= FIRST_REGISTER_RST;
		end else if (cfg.valid) begin
			case (cfg_w.index)
				CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_w.value[6:0];
				CFG_FIRST_REGISTER: first_reg_q <= cfg_w.value;
				default: begin
				end
			endcase
		end
	end

	i2crtc_seq #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.req       (req),
		.dev_addr  (dev_addr_q),
		.first_reg (first_reg_q),
		.buf_rdata (rdata_b),
		.buf_raddr (buf_raddr),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata),
		.nx_line   (nx_line)
	);

	i2crtc_ram #(
		.W     (8),
		.DEPTH (BUFFER_BYTES)
	) u_buf (
		.clk     (clk),
		.we      (buf_we),
		.waddr   (buf_waddr),
		.wdata   (buf_wdata),
		.re_a    (accept && fetch_c),
		.raddr_a (idx_ext[AW-1:0]),
		.rdata_a (rdata_a),
		.raddr_b (buf_raddr),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fetch_q     <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
			fetch_q     <= fetch_c;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= nx_line;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.data.scl_level    = line_q.scl;
	assign result.data.sda_level    = line_q.sda;
	assign result.data.sda_enable   = line_q.en;
	assign result.data.busy_res     = line_q.busy;
	assign result.data.done_res     = line_q.done;
	assign result.data.ack_missing  = line_q.ack;
	assign result.data.fetched_byte = fetch_q ? rdata_a : 8'd0;
endmodule

@@ src/i2crtc_chk.sv @@
module i2crtc_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_bits
);
	// out_bits: scl, sda, en, busy, done, ack, two spare
	logic sda_l, sda_en, busy, done;

	assign sda_l  = out_bits[6];
	assign sda_en = out_bits[5];
	assign busy   = out_bits[4];
	assign done   = out_bits[3];

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction left no result");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done |-> !busy)
		else $error("done reported while still busy");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_en |-> !sda_l)
		else $error("data level high while line released");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("stalled result changed");
endmodule

bind i2c_rtc_buffer_transfer_top i2crtc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_bits  ({result.data.scl_level, result.data.sda_level, result.data.sda_enable,
		result.data.busy_res, result.data.done_res, result.data.ack_missing, 2'b00})
);
